// ===== rtl/julia_escape_time_unit_macros.svh =====
// Assertion macros for the Julia escape-time unit.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef JULIA_ESCAPE_TIME_UNIT_MACROS_SVH
`define JULIA_ESCAPE_TIME_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define JET_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jet assertion failed");
`define JET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jet assertion failed");
`else
`define JET_ASSERT_IMP(label, clk, rst, ante, cons)
`define JET_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/jet_pkg.sv =====
// Package for the Julia escape-time unit: widths, window constants, register
// codes, sequencer states and fixed-point helpers. No dependencies.
`timescale 1ns / 1ps

package jet_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int VAL_W      = FRAC_BITS + 4;
   localparam int MAG_W      = VAL_W - 1;
   localparam int PROD_W     = 2 * VAL_W;
   localparam int EXT_W      = VAL_W + 2;
   localparam int DIV_W      = MAG_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int PIX_W      = 12;
   localparam int CFG_C_W    = 30;
   localparam int LIMIT_W    = 16;
   localparam int SIZE_W     = 13;
   localparam int REM_W      = SIZE_W + 1;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [PROD_W-1:0] ONE       = PROD_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0] HALF_X    = 9 * (ONE / 5) + (9 * (ONE % 5) + 2) / 5;
   localparam logic [PROD_W-1:0] HALF_Y    = 3 * (ONE >> 1);
   localparam logic [PROD_W-1:0] SPAN_X    = HALF_X << 1;
   localparam logic [PROD_W-1:0] SPAN_Y    = HALF_Y << 1;
   localparam logic [PROD_W-1:0] MAX_MAG   = (PROD_W'(1) << MAG_W) - PROD_W'(1);
   localparam logic [PROD_W-1:0] ROOM_X    = MAX_MAG + HALF_X;
   localparam logic [PROD_W-1:0] ROOM_Y    = MAX_MAG + HALF_Y;
   localparam logic [PROD_W-1:0] ESC_BOUND = ONE << 2;

   localparam logic signed [CFG_C_W-1:0] C_REAL_RESET = -30'sd29527900;
   localparam logic signed [CFG_C_W-1:0] C_IMAG_RESET = 30'sd176013130;
   localparam logic [LIMIT_W-1:0]        LIMIT_RESET  = 16'd256;
   localparam logic [SIZE_W-1:0]         WIDTH_RESET  = 13'd1024;
   localparam logic [SIZE_W-1:0]         HEIGHT_RESET = 13'd768;

   typedef enum logic [2:0] {
      REG_C_REAL,
      REG_C_IMAG,
      REG_ITER_LIMIT,
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MAP_X,
      ST_MAP_Y,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ESCAPE,
      ST_CROSS,
      ST_UPDATE,
      ST_DONE
   } jet_state_type;

   // clamp a shifted product magnitude to the largest Q3 value
   function automatic logic [MAG_W-1:0] clamp_mag(input logic [PROD_W-1:0] v);
      logic [MAG_W-1:0] r;
      if (v > MAX_MAG) begin
         r = MAX_MAG[MAG_W-1:0];
      end else begin
         r = v[MAG_W-1:0];
      end
      return r;
   endfunction

   // saturate a widened sum to the Q3 range
   function automatic logic [VAL_W-1:0] sat_val(input logic signed [EXT_W-1:0] v);
      logic signed [EXT_W-1:0] hi;
      logic signed [EXT_W-1:0] lo;
      logic [VAL_W-1:0]        r;
      hi = $signed(EXT_W'(MAX_MAG));
      lo = ~hi;
      if (v > hi) begin
         r = hi[VAL_W-1:0];
      end else if (v < lo) begin
         r = lo[VAL_W-1:0];
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/julia_escape_time_unit.sv =====
// Julia escape-time unit: maps a pixel into the complex window and iterates
// z = z^2 + c on one shared 32x32 multiplier. Depends on jet_pkg and the macros header.
//
//  channel | ports                              | beat
//  --------+------------------------------------+-------------------------------
//  req     | req_valid/req_ready                | pixel_x, pixel_y
//  rsp     | rsp_valid/rsp_ready                | iteration_count
//  csr     | csr_psel/penable/pwrite/paddr/...  | one 32-bit register write/read
//
// From accept to result beat an item runs restoring division for the pixel steps, the
// x and y mapping passes, then per iteration three multiplier passes (cross product,
// two squares), the update and the escape test, until it escapes or reaches the limit.
// One item at a time; req_ready is high in idle even while a result waits, and a
// finished item holds in done until the waiting result beat is taken.
// Reset is synchronous and returns the CSRs and control registers to their reset values.
`timescale 1ns / 1ps
`include "julia_escape_time_unit_macros.svh"

module julia_escape_time_unit
   import jet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_pixel_x,
   input  logic [PIX_W-1:0]      req_pixel_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LIMIT_W-1:0]    rsp_iteration_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic signed [CFG_C_W-1:0] c_real_ff, c_imag_ff;
   logic [LIMIT_W-1:0]        limit_ff;
   logic [SIZE_W-1:0]         width_ff, height_ff;
   logic                      csr_write;
   csr_reg_type               csr_sel;

   jet_state_type             state_ff, state_in;
   logic [PIX_W-1:0]          px_ff, px_in, py_ff, py_in;
   logic [DIV_W-1:0]          quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [REM_W-1:0]          rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic [VAL_W-1:0]          zx_ff, zx_in, zy_ff, zy_in;
   logic [MAG_W-1:0]          sx_ff, sx_in, sy_ff, sy_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [LIMIT_W-1:0]        count_ff, count_in;
   logic                      first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic [VAL_W-1:0]          mag_x, mag_y, mul_a, mul_b, map_x, map_y, esc_sum;
   logic [REM_W-1:0]          div_x_d, div_y_d, rem_x_sh, rem_y_sh;
   logic                      ge_x, ge_y, cross_neg, escaped, rsp_load;
   logic [MAG_W-1:0]          sq_mag, cross_mag;
   logic signed [EXT_W-1:0]   cx_ext, cy_ext, cross_ext, ux_sum, uy_sum;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff <= C_REAL_RESET;
         c_imag_ff <= C_IMAG_RESET;
         limit_ff  <= LIMIT_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            REG_C_REAL:       c_real_ff <= csr_pwdata[CFG_C_W-1:0];
            REG_C_IMAG:       c_imag_ff <= csr_pwdata[CFG_C_W-1:0];
            REG_ITER_LIMIT:   limit_ff  <= csr_pwdata[LIMIT_W-1:0];
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_C_REAL:       csr_prdata = CSR_DATA_W'($unsigned(c_real_ff));
         REG_C_IMAG:       csr_prdata = CSR_DATA_W'($unsigned(c_imag_ff));
         REG_ITER_LIMIT:   csr_prdata = CSR_DATA_W'(limit_ff);
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // datapath around the shared multiplier
   assign mag_x = zx_ff[VAL_W-1] ? (~zx_ff + VAL_W'(1)) : zx_ff;
   assign mag_y = zy_ff[VAL_W-1] ? (~zy_ff + VAL_W'(1)) : zy_ff;
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign div_x_d  = (width_ff == '0) ? REM_W'(1) : REM_W'(width_ff);
   assign div_y_d  = (height_ff == '0) ? REM_W'(1) : REM_W'(height_ff);
   assign rem_x_sh = {rem_x_ff[REM_W-2:0], quo_x_ff[DIV_W-1]};
   assign rem_y_sh = {rem_y_ff[REM_W-2:0], quo_y_ff[DIV_W-1]};
   assign ge_x     = rem_x_sh >= div_x_d;
   assign ge_y     = rem_y_sh >= div_y_d;

   assign map_x = (prod_ff > ROOM_X) ? MAX_MAG[VAL_W-1:0]
                                     : (prod_ff[VAL_W-1:0] - HALF_X[VAL_W-1:0]);
   assign map_y = (prod_ff > ROOM_Y) ? MAX_MAG[VAL_W-1:0]
                                     : (prod_ff[VAL_W-1:0] - HALF_Y[VAL_W-1:0]);

   assign sq_mag    = clamp_mag(prod_ff >> FRAC_BITS);
   assign cross_mag = clamp_mag(prod_ff >> (FRAC_BITS - 1));
   assign cross_neg = zx_ff[VAL_W-1] ^ zy_ff[VAL_W-1];
   assign cross_ext = $signed({3'b000, cross_mag});
   assign cx_ext    = EXT_W'(c_real_ff);
   assign cy_ext    = EXT_W'(c_imag_ff);
   assign ux_sum    = $signed({3'b000, sx_ff}) - $signed({3'b000, sy_ff}) + cx_ext;
   assign uy_sum    = (cross_neg ? -cross_ext : cross_ext) + cy_ext;
   assign esc_sum   = {1'b0, sx_ff} + {1'b0, sq_mag};
   assign escaped   = esc_sum > ESC_BOUND[VAL_W-1:0];

   assign rsp_load  = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_ready);

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         first_ff     <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      quo_x_ff     <= quo_x_in;
      quo_y_ff     <= quo_y_in;
      rem_x_ff     <= rem_x_in;
      rem_y_ff     <= rem_y_in;
      zx_ff        <= zx_in;
      zy_ff        <= zy_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      prod_ff      <= prod_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      quo_x_in     = quo_x_ff;
      quo_y_in     = quo_y_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      div_cnt_in   = div_cnt_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_count_in = rsp_count_ff;
      mul_a        = mag_x;
      mul_b        = mag_y;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               px_in      = req_pixel_x;
               py_in      = req_pixel_y;
               quo_x_in   = SPAN_X[DIV_W-1:0];
               quo_y_in   = SPAN_Y[DIV_W-1:0];
               rem_x_in   = '0;
               rem_y_in   = '0;
               div_cnt_in = DIV_CNT_W'(DIV_W - 1);
               count_in   = '0;
               first_in   = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_x_in   = ge_x ? (rem_x_sh - div_x_d) : rem_x_sh;
            rem_y_in   = ge_y ? (rem_y_sh - div_y_d) : rem_y_sh;
            quo_x_in   = {quo_x_ff[DIV_W-2:0], ge_x};
            quo_y_in   = {quo_y_ff[DIV_W-2:0], ge_y};
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_MAP_X;
            end
         end
         ST_MAP_X: begin
            mul_a    = VAL_W'(px_ff);
            mul_b    = VAL_W'(quo_x_ff);
            state_in = ST_MAP_Y;
         end
         ST_MAP_Y: begin
            zx_in    = map_x;
            mul_a    = VAL_W'(py_ff);
            mul_b    = VAL_W'(quo_y_ff);
            state_in = ST_SQ_X;
         end
         ST_SQ_X: begin
            if (first_ff) begin
               zy_in = map_y;
            end
            mul_a    = mag_x;
            mul_b    = mag_x;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            sx_in    = sq_mag;
            mul_a    = mag_y;
            mul_b    = mag_y;
            state_in = ST_ESCAPE;
         end
         ST_ESCAPE: begin
            sy_in = sq_mag;
            priority if (first_ff) begin
               first_in = 1'b0;
               state_in = ST_CROSS;
            end else if (escaped) begin
               state_in = ST_DONE;
            end else begin
               count_in = count_ff + LIMIT_W'(1);
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: begin
            if (count_ff >= limit_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            zx_in    = sat_val(ux_sum);
            zy_in    = sat_val(uy_sum);
            state_in = ST_SQ_X;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `JET_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_valid && req_ready, state_ff == ST_DIV)
   `JET_ASSERT_IMP(a_count_within_limit, clock, reset, state_ff != ST_IDLE, count_ff <= limit_ff)
   `JET_ASSERT_NEXT(a_done_emits, clock, reset, rsp_load, rsp_valid_ff && state_ff == ST_IDLE)

endmodule
